@@ rtl/vna_pkg.sv @@
// Package for the vertex normal accumulator.
// Holds sizes, opcodes and fixed-point constants; no dependencies.
`timescale 1ns / 1ps
package vna_pkg;
    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int VC_W         = 11;
    localparam int CORNER_W     = 16;
    localparam int LIM_W        = CORNER_W + 1;
    localparam int POS_W        = 16;
    localparam int DIFF_W       = POS_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int CROSS_W      = PROD_W + 1;
    localparam int ACC_W        = 48;
    localparam int FRAC         = 14;
    localparam int QW           = FRAC + 1;
    localparam int NORM_W       = 16;
    localparam int MAG_W        = 31;
    localparam int NUM_W        = MAG_W + FRAC + 1;
    localparam int ROOT_W       = 32;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic signed [ACC_W:0] ACC_MAX = {2'b00, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W:0] ACC_MIN = {2'b11, {(ACC_W-1){1'b0}}};
endpackage

@@ rtl/vertex_normal_accumulator.sv @@
// Top level of the area-weighted vertex normal accumulator.
// Depends on vna_pkg and vna_norm; holds position and accumulator memories.
//
// Usage:
//   Command channel: an item transfers at a clock edge with start high and
//   busy low. opcode selects load (write position, clear accumulator),
//   triangle (add cross product to three accumulators) or read.
//   Configuration: vertex_count transfers when cfg_valid and cfg_ready are
//   high; cfg_ready is always high. Write it only while busy is low.
//   Result: a read item produces one result, shown for one cycle with
//   result_valid high; the receiver cannot stall it.
//   Timing: a load does not raise busy. A triangle whose corners are all in
//   range holds busy through three position reads, difference, multiply and
//   cross product stages, then a read-modify-write per corner on the single
//   accumulator port. A read of an index in range holds busy while the
//   normalizer runs a bit-a-cycle scaling shift, a 32-step square root and
//   three 15-step divides (a zero sum skips them); its result shows in the
//   first cycle with busy low. An out-of-range read answers the cycle after
//   its transfer. Reset clears the control state and vertex_count; memory
//   contents are undefined until loaded.
`timescale 1ns / 1ps
module vertex_normal_accumulator
    import vna_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               opcode,
    input  logic [ADDR_W-1:0]        vertex_index,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [POS_W-1:0]  pos_z,
    input  logic [CORNER_W-1:0]      corner_a,
    input  logic [CORNER_W-1:0]      corner_b,
    input  logic [CORNER_W-1:0]      corner_c,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [VC_W-1:0]          cfg_data,
    output logic                     result_valid,
    output logic signed [NORM_W-1:0] norm_x,
    output logic signed [NORM_W-1:0] norm_y,
    output logic signed [NORM_W-1:0] norm_z,
    output logic                     index_ok
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_P0     = 4'd1;
    localparam logic [3:0] S_P1     = 4'd2;
    localparam logic [3:0] S_P2     = 4'd3;
    localparam logic [3:0] S_P3     = 4'd4;
    localparam logic [3:0] S_DIFF   = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_CROSS  = 4'd7;
    localparam logic [3:0] S_ARD    = 4'd8;
    localparam logic [3:0] S_AWR    = 4'd9;
    localparam logic [3:0] S_RRD    = 4'd10;
    localparam logic [3:0] S_RSTART = 4'd11;
    localparam logic [3:0] S_NORM   = 4'd12;

    typedef logic signed [ACC_W-1:0] acc_t;

    logic [3*POS_W-1:0] pos_mem [MAX_VERTICES];
    logic [3*ACC_W-1:0] acc_mem [MAX_VERTICES];

    logic [3:0]          state_reg;
    logic [VC_W-1:0]     vcount_reg;
    logic [ADDR_W-1:0]   corner_reg [3];
    logic [ADDR_W-1:0]   vi_reg;
    logic [1:0]          k_reg;
    logic [3*POS_W-1:0]  pos_rd_reg;
    logic [3*ACC_W-1:0]  acc_rd_reg;
    logic [3*POS_W-1:0]  pa_reg;
    logic [3*POS_W-1:0]  pb_reg;
    logic signed [DIFF_W-1:0]  u_reg [3];
    logic signed [DIFF_W-1:0]  w_reg [3];
    logic signed [PROD_W-1:0]  p_reg [6];
    logic signed [CROSS_W-1:0] n_reg [3];
    logic                      res_valid_reg;
    logic signed [NORM_W-1:0]  rx_reg;
    logic signed [NORM_W-1:0]  ry_reg;
    logic signed [NORM_W-1:0]  rz_reg;
    logic                      rok_reg;

    logic [LIM_W-1:0]    lim;
    logic                tri_ok;
    logic                accept;
    logic [ADDR_W-1:0]   pos_raddr;
    logic [ADDR_W-1:0]   acc_raddr;
    logic                acc_we;
    logic [ADDR_W-1:0]   acc_waddr;
    logic [3*ACC_W-1:0]  acc_wdata;
    logic [3*ACC_W-1:0]  acc_sum;
    logic signed [ACC_W:0] s;
    logic                norm_start;
    logic                norm_done;
    logic signed [NORM_W-1:0] nqx;
    logic signed [NORM_W-1:0] nqy;
    logic signed [NORM_W-1:0] nqz;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (LIM_W'(vcount_reg) < LIM_W'(MAX_VERTICES))
        begin
            lim = LIM_W'(vcount_reg);
        end
        else
        begin
            lim = LIM_W'(MAX_VERTICES);
        end
        tri_ok = (LIM_W'(corner_a) < lim) && (LIM_W'(corner_b) < lim)
                 && (LIM_W'(corner_c) < lim);

        case (state_reg)
            S_P0:    pos_raddr = corner_reg[0];
            S_P1:    pos_raddr = corner_reg[1];
            default: pos_raddr = corner_reg[2];
        endcase

        if (state_reg == S_RRD)
        begin
            acc_raddr = vi_reg;
        end
        else
        begin
            acc_raddr = corner_reg[k_reg];
        end

        for (int i = 0; i < 3; i++)
        begin
            s = $signed({acc_rd_reg[i*ACC_W+ACC_W-1], acc_rd_reg[i*ACC_W +: ACC_W]})
                + (ACC_W+1)'(n_reg[i]);
            if (s > ACC_MAX)
            begin
                s = ACC_MAX;
            end
            else if (s < ACC_MIN)
            begin
                s = ACC_MIN;
            end
            acc_sum[i*ACC_W +: ACC_W] = s[ACC_W-1:0];
        end

        if (accept && opcode == OP_LOAD)
        begin
            acc_we    = 1'b1;
            acc_waddr = vertex_index;
            acc_wdata = '0;
        end
        else
        begin
            acc_we    = (state_reg == S_AWR);
            acc_waddr = corner_reg[k_reg];
            acc_wdata = acc_sum;
        end

        norm_start = (state_reg == S_RSTART);
    end

    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_LOAD)
        begin
            pos_mem[vertex_index] <= {pos_z, pos_y, pos_x};
        end
        pos_rd_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_rd_reg <= acc_mem[acc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            corner_reg[0] <= corner_a[ADDR_W-1:0];
            corner_reg[1] <= corner_b[ADDR_W-1:0];
            corner_reg[2] <= corner_c[ADDR_W-1:0];
            vi_reg        <= vertex_index;
        end
        if (state_reg == S_P1)
        begin
            pa_reg <= pos_rd_reg;
        end
        if (state_reg == S_P2)
        begin
            pb_reg <= pos_rd_reg;
        end
        if (state_reg == S_P3)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= DIFF_W'($signed(pb_reg[i*POS_W +: POS_W]))
                            - DIFF_W'($signed(pa_reg[i*POS_W +: POS_W]));
                w_reg[i] <= DIFF_W'($signed(pos_rd_reg[i*POS_W +: POS_W]))
                            - DIFF_W'($signed(pa_reg[i*POS_W +: POS_W]));
            end
        end
        if (state_reg == S_MUL)
        begin
            p_reg[0] <= u_reg[1] * w_reg[2];
            p_reg[1] <= u_reg[2] * w_reg[1];
            p_reg[2] <= u_reg[2] * w_reg[0];
            p_reg[3] <= u_reg[0] * w_reg[2];
            p_reg[4] <= u_reg[0] * w_reg[1];
            p_reg[5] <= u_reg[1] * w_reg[0];
        end
        if (state_reg == S_CROSS)
        begin
            n_reg[0] <= CROSS_W'(p_reg[0]) - CROSS_W'(p_reg[1]);
            n_reg[1] <= CROSS_W'(p_reg[2]) - CROSS_W'(p_reg[3]);
            n_reg[2] <= CROSS_W'(p_reg[4]) - CROSS_W'(p_reg[5]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcount_reg    <= '0;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    res_valid_reg <= accept && opcode == OP_READ
                                     && (LIM_W'(vertex_index) >= lim);
                    if (accept && opcode == OP_TRI && tri_ok)
                    begin
                        state_reg <= S_P0;
                    end
                    else if (accept && opcode == OP_READ)
                    begin
                        if (LIM_W'(vertex_index) < lim)
                        begin
                            state_reg <= S_RRD;
                        end
                        else
                        begin
                            rx_reg        <= '0;
                            ry_reg        <= '0;
                            rz_reg        <= '0;
                            rok_reg       <= 1'b0;
                        end
                    end
                end
                S_P0:    state_reg <= S_P1;
                S_P1:    state_reg <= S_P2;
                S_P2:    state_reg <= S_P3;
                S_P3:    state_reg <= S_MUL;
                S_MUL:   state_reg <= S_CROSS;
                S_CROSS:
                begin
                    k_reg     <= 2'd0;
                    state_reg <= S_ARD;
                end
                S_ARD:   state_reg <= S_AWR;
                S_AWR:
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_ARD;
                    end
                end
                S_RRD:    state_reg <= S_RSTART;
                S_RSTART: state_reg <= S_NORM;
                S_NORM:
                begin
                    res_valid_reg <= norm_done;
                    if (norm_done)
                    begin
                        rx_reg        <= nqx;
                        ry_reg        <= nqy;
                        rz_reg        <= nqz;
                        rok_reg       <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    vna_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vx    (acc_t'(acc_rd_reg[0*ACC_W +: ACC_W])),
        .vy    (acc_t'(acc_rd_reg[1*ACC_W +: ACC_W])),
        .vz    (acc_t'(acc_rd_reg[2*ACC_W +: ACC_W])),
        .done  (norm_done),
        .qx    (nqx),
        .qy    (nqy),
        .qz    (nqz)
    );

    assign result_valid = res_valid_reg;
    assign norm_x       = rx_reg;
    assign norm_y       = ry_reg;
    assign norm_z       = rz_reg;
    assign index_ok     = rok_reg;
endmodule

@@ rtl/vna_norm.sv @@
// Iterative unit-length normalizer for one 3-component accumulator.
// Depends on vna_pkg; shared shift, multiply, square root and divide steps.
`timescale 1ns / 1ps
module vna_norm
    import vna_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [ACC_W-1:0]  vx,
    input  logic signed [ACC_W-1:0]  vy,
    input  logic signed [ACC_W-1:0]  vz,
    output logic                     done,
    output logic signed [NORM_W-1:0] qx,
    output logic signed [NORM_W-1:0] qy,
    output logic signed [NORM_W-1:0] qz
);
    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_SQRT  = 3'd3;
    localparam logic [2:0] N_DSET  = 3'd4;
    localparam logic [2:0] N_DSTEP = 3'd5;

    logic [2:0]             state_reg;
    logic [ACC_W-1:0]       m_reg [3];
    logic [2:0]             sgn_reg;
    logic [1:0]             k_reg;
    logic [63:0]            x_reg;
    logic [63:0]            res_reg;
    logic [63:0]            bit_reg;
    logic [4:0]             cnt_reg;
    logic [ROOT_W-1:0]      len_reg;
    logic [ROOT_W-1:0]      rem_reg;
    logic [FRAC:0]          lo_reg;
    logic [QW-1:0]          quo_reg;
    logic signed [NORM_W-1:0] q_reg [3];
    logic                   done_reg;

    logic [ACC_W-1:0]       mx;
    logic [MAG_W-1:0]       msel;
    logic [63:0]            trial;
    logic [NUM_W-1:0]       num;
    logic [ROOT_W:0]        t;
    logic [QW-1:0]          quo_next;
    logic [QW-1:0]          qclamp;

    always_comb
    begin
        mx = m_reg[0];
        if (m_reg[1] > mx)
        begin
            mx = m_reg[1];
        end
        if (m_reg[2] > mx)
        begin
            mx = m_reg[2];
        end
        case (k_reg)
            2'd0:    msel = m_reg[0][MAG_W-1:0];
            2'd1:    msel = m_reg[1][MAG_W-1:0];
            default: msel = m_reg[2][MAG_W-1:0];
        endcase
        trial = res_reg + bit_reg;
        num = {msel, {FRAC{1'b0}}} + NUM_W'(len_reg >> 1);
        t = {rem_reg, lo_reg[FRAC]};
        if (t >= {1'b0, len_reg})
        begin
            quo_next = {quo_reg[QW-2:0], 1'b1};
        end
        else
        begin
            quo_next = {quo_reg[QW-2:0], 1'b0};
        end
        qclamp = (quo_next > QW'(1 << FRAC)) ? QW'(1 << FRAC) : quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                N_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        sgn_reg  <= {vz[ACC_W-1], vy[ACC_W-1], vx[ACC_W-1]};
                        m_reg[0] <= vx[ACC_W-1] ? ACC_W'(-vx) : ACC_W'(vx);
                        m_reg[1] <= vy[ACC_W-1] ? ACC_W'(-vy) : ACC_W'(vy);
                        m_reg[2] <= vz[ACC_W-1] ? ACC_W'(-vz) : ACC_W'(vz);
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    if (mx == '0)
                    begin
                        q_reg[0]  <= '0;
                        q_reg[1]  <= '0;
                        q_reg[2]  <= NORM_W'(1 << FRAC);
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                    else if (mx[ACC_W-1:MAG_W] != '0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            m_reg[i] <= m_reg[i] >> 1;
                        end
                    end
                    else if (!mx[MAG_W-1])
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            m_reg[i] <= m_reg[i] << 1;
                        end
                    end
                    else
                    begin
                        k_reg     <= 2'd0;
                        x_reg     <= '0;
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    x_reg <= x_reg + 64'(msel * msel);
                    if (k_reg == 2'd2)
                    begin
                        res_reg   <= '0;
                        bit_reg   <= 64'd1 << 62;
                        cnt_reg   <= '0;
                        state_reg <= N_SQRT;
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                N_SQRT:
                begin
                    if (x_reg >= trial)
                    begin
                        x_reg   <= x_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        k_reg     <= 2'd0;
                        state_reg <= N_DSET;
                    end
                end
                N_DSET:
                begin
                    if (cnt_reg == 5'd0)
                    begin
                        len_reg <= res_reg[ROOT_W-1:0];
                        cnt_reg <= 5'd1;
                    end
                    else
                    begin
                        rem_reg   <= ROOT_W'(num >> QW);
                        lo_reg    <= num[FRAC:0];
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= N_DSTEP;
                    end
                end
                N_DSTEP:
                begin
                    if (t >= {1'b0, len_reg})
                    begin
                        rem_reg <= ROOT_W'(t - {1'b0, len_reg});
                    end
                    else
                    begin
                        rem_reg <= t[ROOT_W-1:0];
                    end
                    lo_reg  <= lo_reg << 1;
                    quo_reg <= quo_next;
                    if (cnt_reg == 5'(QW - 1))
                    begin
                        q_reg[k_reg] <= sgn_reg[k_reg] ? -NORM_W'(qclamp) : NORM_W'(qclamp);
                        cnt_reg <= 5'd1;
                        if (k_reg == 2'd2)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= N_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= N_DSET;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign qx   = q_reg[0];
    assign qy   = q_reg[1];
    assign qz   = q_reg[2];
endmodule

@@ tb/vertex_normal_accumulator_tb.sv @@
// Testbench for vertex_normal_accumulator: drives load, triangle and read commands
// and checks every read result against a scoreboard that predicts the normals.
// Depends on vna_pkg and the RTL of the block.
`timescale 1ns / 1ps
module vertex_normal_accumulator_tb;
    import vna_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam longint SAT_HI = (64'sd1 <<< 47) - 1;
    localparam longint SAT_LO = -(64'sd1 <<< 47);

    typedef struct {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic                     ok;
    } normal_t;

    class normal_scoreboard;
        longint    vtx_pos[MAX_VERTICES][3];
        longint    vtx_sum[MAX_VERTICES][3];
        int        vcount;
        normal_t   pending[$];
        int        errors;

        function new();
            vcount = 0;
            errors = 0;
        endfunction

        function int limit();
            return (vcount < MAX_VERTICES) ? vcount : MAX_VERTICES;
        endfunction

        function longint sat_add(longint a, longint b);
            longint s;
            s = a + b;
            if (s > SAT_HI) return SAT_HI;
            if (s < SAT_LO) return SAT_LO;
            return s;
        endfunction

        function longint unsigned root(longint unsigned x);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function normal_t unit_normal(longint v0, longint v1, longint v2);
            longint          v[3];
            longint unsigned m[3];
            longint unsigned mx;
            longint unsigned len;
            longint unsigned r;
            longint          q[3];
            normal_t         res;
            v[0] = v0;
            v[1] = v1;
            v[2] = v2;
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = (v[i] < 0) ? -v[i] : v[i];
                if (m[i] > mx) mx = m[i];
            end
            res.ok = 1'b1;
            if (mx == 0) begin
                res.nx = 0;
                res.ny = 0;
                res.nz = 16'sd1 <<< FRAC;
                return res;
            end
            while (mx >= (64'd1 << 31)) begin
                mx = mx >> 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            while (mx < (64'd1 << 30)) begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            end
            len = root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
            for (int i = 0; i < 3; i++) begin
                r = ((m[i] << FRAC) + (len >> 1)) / len;
                if (r > (64'd1 << FRAC)) r = 64'd1 << FRAC;
                q[i] = (v[i] < 0) ? -longint'(r) : longint'(r);
            end
            res.nx = q[0][NORM_W-1:0];
            res.ny = q[1][NORM_W-1:0];
            res.nz = q[2][NORM_W-1:0];
            return res;
        endfunction

        function void note_input(logic [1:0] op, int vi, logic signed [POS_W-1:0] px,
                                 logic signed [POS_W-1:0] py, logic signed [POS_W-1:0] pz,
                                 int ca, int cb, int cc);
            longint  u[3];
            longint  w[3];
            longint  n[3];
            int      lim;
            normal_t res;
            lim = limit();
            case (op)
                OP_LOAD: begin
                    vtx_pos[vi][0] = px;
                    vtx_pos[vi][1] = py;
                    vtx_pos[vi][2] = pz;
                    for (int i = 0; i < 3; i++) vtx_sum[vi][i] = 0;
                end
                OP_TRI: begin
                    if (ca < lim && cb < lim && cc < lim) begin
                        for (int i = 0; i < 3; i++) begin
                            u[i] = vtx_pos[cb][i] - vtx_pos[ca][i];
                            w[i] = vtx_pos[cc][i] - vtx_pos[ca][i];
                        end
                        n[0] = u[1] * w[2] - u[2] * w[1];
                        n[1] = u[2] * w[0] - u[0] * w[2];
                        n[2] = u[0] * w[1] - u[1] * w[0];
                        for (int i = 0; i < 3; i++) begin
                            vtx_sum[ca][i] = sat_add(vtx_sum[ca][i], n[i]);
                            vtx_sum[cb][i] = sat_add(vtx_sum[cb][i], n[i]);
                            vtx_sum[cc][i] = sat_add(vtx_sum[cc][i], n[i]);
                        end
                    end
                end
                OP_READ: begin
                    if (vi < lim)
                        res = unit_normal(vtx_sum[vi][0], vtx_sum[vi][1], vtx_sum[vi][2]);
                    else begin
                        res.nx = 0;
                        res.ny = 0;
                        res.nz = 0;
                        res.ok = 1'b0;
                    end
                    pending = {pending, res};
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [NORM_W-1:0] nx, logic signed [NORM_W-1:0] ny,
                                   logic signed [NORM_W-1:0] nz, logic ok);
            normal_t e;
            if (pending.size() == 0) begin
                $error("result with no read outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (nx !== e.nx) begin
                $error("norm_x: expected %0d, got %0d", e.nx, nx);
                errors++;
            end
            if (ny !== e.ny) begin
                $error("norm_y: expected %0d, got %0d", e.ny, ny);
                errors++;
            end
            if (nz !== e.nz) begin
                $error("norm_z: expected %0d, got %0d", e.nz, nz);
                errors++;
            end
            if (ok !== e.ok) begin
                $error("index_ok: expected %0d, got %0d", e.ok, ok);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               opcode;
    logic [ADDR_W-1:0]        vertex_index;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic [CORNER_W-1:0]      corner_a;
    logic [CORNER_W-1:0]      corner_b;
    logic [CORNER_W-1:0]      corner_c;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [VC_W-1:0]          cfg_data;
    logic                     result_valid;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic                     index_ok;

    normal_scoreboard sb;
    bit               calm;
    bit               loaded[MAX_VERTICES];
    int               loaded_q[$];

    vertex_normal_accumulator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .vertex_index (vertex_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .norm_x       (norm_x),
        .norm_y       (norm_y),
        .norm_z       (norm_z),
        .index_ok     (index_ok)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(norm_x, norm_y, norm_z, index_ok);
    end

    task automatic issue(logic [1:0] op, int vi, int px, int py, int pz,
                         int ca, int cb, int cc);
        while (!calm && $urandom_range(99) < 32) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        opcode       <= op;
        vertex_index <= vi[ADDR_W-1:0];
        pos_x        <= px[POS_W-1:0];
        pos_y        <= py[POS_W-1:0];
        pos_z        <= pz[POS_W-1:0];
        corner_a     <= ca[CORNER_W-1:0];
        corner_b     <= cb[CORNER_W-1:0];
        corner_c     <= cc[CORNER_W-1:0];
        do @(posedge clk); while (busy);
        sb.note_input(op, vi, px[POS_W-1:0], py[POS_W-1:0], pz[POS_W-1:0], ca, cb, cc);
        if (op == OP_LOAD && !loaded[vi]) begin
            loaded[vi] = 1'b1;
            loaded_q = {loaded_q, vi};
        end
    endtask

    task automatic load(int vi, int px, int py, int pz);
        issue(OP_LOAD, vi, px, py, pz, $urandom, $urandom, $urandom);
    endtask

    task automatic tri_add(int ca, int cb, int cc);
        issue(OP_TRI, $urandom, $urandom, $urandom, $urandom, ca, cb, cc);
    endtask

    task automatic read(int vi);
        issue(OP_READ, vi, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // hold until every read has answered and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0 || busy) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_count(int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value[VC_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.vcount = value;
    endtask

    function automatic int pick_loaded(int lim);
        int v;
        for (int i = 0; i < 30; i++) begin
            if (loaded_q.size() == 0) return -1;
            v = loaded_q[$urandom_range(loaded_q.size() - 1)];
            if (v < lim) return v;
        end
        return -1;
    endfunction

    function automatic int pick_corner(int lim);
        int v;
        v = pick_loaded(lim);
        return (v < 0) ? $urandom_range(65535, lim) : v;
    endfunction

    task automatic random_phase(int count, int items);
        int lim;
        int vi;
        int ca;
        int cb;
        int cc;
        int sel;
        write_count(count);
        lim = sb.limit();
        for (int n = 0; n < items; n++) begin
            calm = (n >= items / 2 && n < items / 2 + 30);
            sel = $urandom_range(99);
            if (sel < 30) begin
                vi = ($urandom_range(3) == 0) ? $urandom_range(MAX_VERTICES - 1)
                                              : $urandom_range((lim > 0) ? lim - 1 : 15);
                if ($urandom_range(4) == 0)
                    load(vi, $urandom_range(1) ? 32767 : -32768, $urandom, $urandom);
                else
                    load(vi, $urandom, $urandom, $urandom);
            end
            else if (sel < 70) begin
                ca = pick_corner(lim);
                cb = pick_corner(lim);
                cc = pick_corner(lim);
                if ($urandom_range(9) == 0) cb = $urandom_range(65535, lim);
                tri_add(ca, cb, cc);
            end
            else if (sel < 95) begin
                vi = pick_loaded(lim);
                if (vi < 0 || $urandom_range(9) == 0)
                    vi = (lim < MAX_VERTICES) ? $urandom_range(MAX_VERTICES - 1, lim) : -1;
                if (vi >= 0) read(vi);
            end
            else
                issue(OP_NOP, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        #12_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        sb           = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_NOP;
        vertex_index = '0;
        pos_x        = '0;
        pos_y        = '0;
        pos_z        = '0;
        corner_a     = '0;
        corner_b     = '0;
        corner_c     = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        calm         = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // count of zero: everything out of range, loads still land
        read(0);
        load(0, 0, 0, 0);
        tri_add(0, 0, 0);
        read(1023);
        issue(OP_NOP, 0, 0, 0, 0, 0, 0, 0);

        write_count(8);
        load(0, -32768, 0, 0);
        load(1, 32767, -32768, 0);
        load(2, 32767, 32767, 0);
        load(7, 32767, 32767, 32767);
        read(0);
        tri_add(0, 1, 2);
        read(0);
        read(1);
        tri_add(0, 0, 1);
        tri_add(7, 7, 7);
        tri_add(0, 1, 8);
        tri_add(65535, 1, 2);
        tri_add(2, 1, 0);
        read(2);
        read(7);
        read(8);
        read(1023);
        load(1023, -1, -1, -1);

        // repeat one large triangle on three vertices back to back
        calm = 1'b1;
        for (int n = 0; n < 20; n++) tri_add(0, 1, 2);
        calm = 1'b0;
        read(0);
        read(1);
        read(2);
        tri_add(2, 1, 0);
        read(2);

        random_phase(1024, 90);
        random_phase(3, 60);
        random_phase(2047, 90);
        random_phase($urandom_range(40, 4), 80);
        random_phase(0, 20);
        random_phase(1023, 70);

        drain();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
